[hdl/cartridge_bank_mapper_with_irq_top_macros.svh]
// assertion macros used by the checker file
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_MACROS_SVH

// implication checked while out of reset
`define CBMI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbmi check failed");

// next-cycle implication checked while out of reset
`define CBMI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbmi check failed");

// next-cycle implication checked through reset as well
`define CBMI_ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbmi check failed");

`endif

[hdl/cbmi_pkg.sv]
// types and constants for the cartridge bank mapper
package cbmi_pkg;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_TICK  = 2'd1,
    OP_CPU_XLATE = 2'd2,
    OP_PPU_XLATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REGION_NONE      = 2'd0,
    REGION_PROGRAM   = 2'd1,
    REGION_PATTERN   = 2'd2,
    REGION_NAMETABLE = 2'd3
  } region_t;

  // write decode group, address bits 6:4
  typedef enum logic [2:0] {
    WGRP_PROGRAM   = 3'd0,
    WGRP_PATTERN_LO = 3'd1,
    WGRP_PATTERN_HI = 3'd2,
    WGRP_IRQ_ON    = 3'd3,
    WGRP_IRQ_OFF   = 3'd4,
    WGRP_NAMETABLE = 3'd5,
    WGRP_NONE_6    = 3'd6,
    WGRP_NONE_7    = 3'd7
  } wgrp_t;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAPPED_W = 17;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [3:0] PRG_RESET      = 4'hF;
  localparam logic [1:0] PRG_LAST_INDEX = 2'd3;
  localparam logic [1:0] PRG_LAST_HIGH  = 2'b11;

  typedef struct packed {
    logic          irq_line;
    region_t       region;
    logic [MAPPED_W-1:0] mapped_address;
  } result_t;

endpackage

[hdl/cartridge_bank_mapper_with_irq_top.sv]
// cartridge bank mapper with cycle-counting interrupt, top level
//
// one input stream carries bus events: s_tuser holds the operation (cpu write,
// cpu cycle tick, cpu address translate, ppu address translate) and s_tdata
// holds address and write data. every accepted transfer produces exactly one
// result transfer on the m_ side: the interrupt line as it stands after the
// event, the region and the flat mapped address.
// the mapper state updates in the cycle of the input transfer and the result
// is registered in the output register, or in the skid register while a result is stalled.
// throughput is one transfer per cycle while the receiver takes results;
// a two-entry output buffer (output register plus skid register)
// keeps s_tready high while one result waits for the receiver.
// when the receiver stalls, the result holds on m_tdata/m_tuser; a second
// result goes into the skid register and s_tready drops until it drains.
// rst (synchronous, active high) restores all program banks to fifteen,
// pattern banks and nametable pages to zero, disables and releases the
// interrupt and empties the output buffer.
module cartridge_bank_mapper_with_irq_top
  import cbmi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // address[15:0], write_data[23:16]
  input  logic [1:0]           s_tuser,   // op[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // irq_line[0], mapped_address[17:1], zero[23:18]
  output logic [1:0]           m_tuser    // region[1:0]
);

  logic [3:0] program_banks [4];
  logic [3:0] program_banks_next [4];
  logic [6:0] pattern_banks [8];
  logic [6:0] pattern_banks_next [8];
  logic [3:0] nametable_pages;
  logic [3:0] nametable_pages_next;
  logic       irq_enable;
  logic       irq_enable_next;
  logic [7:0] cycle_counter;
  logic [7:0] cycle_counter_next;
  logic       irq_pending;
  logic       irq_pending_next;

  logic       accept;
  op_t        op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  wgrp_t      wgrp;
  logic [1:0] widx;
  logic [13:0] ppu_addr;
  logic [7:0] count_dec;
  result_t    result;

  result_t    out_res;
  logic       out_valid;
  result_t    skid_res;
  logic       skid_valid;

  assign accept     = s_tvalid && s_tready;
  assign op         = op_t'(s_tuser);
  assign address    = s_tdata[ADDR_W-1:0];
  assign write_data = s_tdata[ADDR_W +: DATA_W];
  assign wgrp       = wgrp_t'(address[6:4]);
  assign widx       = address[1:0];
  assign ppu_addr   = address[13:0];
  assign count_dec  = cycle_counter - 8'd1;

  always_comb begin
    program_banks_next   = program_banks;
    pattern_banks_next   = pattern_banks;
    nametable_pages_next = nametable_pages;
    irq_enable_next      = irq_enable;
    cycle_counter_next   = cycle_counter;
    irq_pending_next     = irq_pending;
    if (accept) begin
      case (op)
        OP_CPU_WRITE: begin
          if (address[15]) begin
            case (wgrp)
              WGRP_PROGRAM: begin
                if (widx == PRG_LAST_INDEX) begin
                  program_banks_next[widx] = {PRG_LAST_HIGH, write_data[1:0]};
                end else begin
                  program_banks_next[widx] = write_data[3:0];
                end
              end
              WGRP_PATTERN_LO: pattern_banks_next[{1'b0, widx}] = write_data[6:0];
              WGRP_PATTERN_HI: pattern_banks_next[{1'b1, widx}] = write_data[6:0];
              WGRP_IRQ_ON:     irq_enable_next = 1'b1;
              WGRP_IRQ_OFF: begin
                irq_enable_next    = 1'b0;
                cycle_counter_next = 8'd0;
                irq_pending_next   = 1'b0;
              end
              WGRP_NAMETABLE:  nametable_pages_next[widx] = write_data[0];
              default: ;
            endcase
          end
        end
        OP_CPU_TICK: begin
          if (irq_enable) begin
            cycle_counter_next = count_dec;
            if (count_dec == 8'd0) begin
              irq_pending_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.irq_line       = irq_pending_next;
    result.region         = REGION_NONE;
    result.mapped_address = '0;
    case (op)
      OP_CPU_XLATE: begin
        if (address[15]) begin
          result.region         = REGION_PROGRAM;
          result.mapped_address = {program_banks[address[14:13]], address[12:0]};
        end
      end
      OP_PPU_XLATE: begin
        if (!ppu_addr[13]) begin
          result.region         = REGION_PATTERN;
          result.mapped_address = {pattern_banks[ppu_addr[12:10]], ppu_addr[9:0]};
        end else begin
          result.region         = REGION_NAMETABLE;
          result.mapped_address = {6'd0, nametable_pages[ppu_addr[11:10]], ppu_addr[9:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        program_banks[i] <= PRG_RESET;
      end
      for (int i = 0; i < 8; i++) begin
        pattern_banks[i] <= '0;
      end
      nametable_pages <= '0;
      irq_enable      <= 1'b0;
      cycle_counter   <= '0;
      irq_pending     <= 1'b0;
    end else begin
      program_banks   <= program_banks_next;
      pattern_banks   <= pattern_banks_next;
      nametable_pages <= nametable_pages_next;
      irq_enable      <= irq_enable_next;
      cycle_counter   <= cycle_counter_next;
      irq_pending     <= irq_pending_next;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_valid <= 1'b1;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= result;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_res <= result;
      end
    end else if (accept) begin
      skid_res <= result;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.region;
  assign m_tdata  = {{(M_TDATA_W - MAPPED_W - 1){1'b0}}, out_res.mapped_address,
                     out_res.irq_line};

endmodule

[hdl/cbmi_checker.sv]
// port-level checker for the cartridge bank mapper, bound to the top level
`include "cartridge_bank_mapper_with_irq_top_macros.svh"

module cbmi_checker
  import cbmi_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [1:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  // output buffer is empty after reset
  `CBMI_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !m_tvalid)

  // stalled result holds
  `CBMI_ASSERT_NXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // input only backs up while a result is waiting
  `CBMI_ASSERT_IMP(a_ready_only_when_full, clk, rst, !s_tready, m_tvalid)

  // a write or tick into an empty buffer gives a region-less, zero-address result
  `CBMI_ASSERT_NXT(a_write_tick_result, clk, rst,
    s_tvalid && s_tready && !m_tvalid &&
      (s_tuser == OP_CPU_WRITE || s_tuser == OP_CPU_TICK),
    m_tvalid && m_tuser == REGION_NONE && m_tdata[MAPPED_W:1] == '0)

  // a ppu pattern translate into an empty buffer keeps its in-page offset
  `CBMI_ASSERT_NXT(a_ppu_pattern_result, clk, rst,
    s_tvalid && s_tready && !m_tvalid && s_tuser == OP_PPU_XLATE && !s_tdata[13],
    m_tvalid && m_tuser == REGION_PATTERN && m_tdata[10:1] == $past(s_tdata[9:0]))

endmodule

bind cartridge_bank_mapper_with_irq_top cbmi_checker u_cbmi_checker (.*);
